### hw/rtl/lsdb_pkg.sv
package lsdb_pkg;

    localparam logic [1:0] OP_INSTALL = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic       REG_OWN_ID   = 1'b0;
    localparam logic       REG_LIFETIME = 1'b1;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LOCAL = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [1:0] KIND_DUP   = 2'd0;
    localparam logic [1:0] KIND_FRESH = 2'd1;
    localparam logic [1:0] KIND_NEWER = 2'd2;
    localparam logic [1:0] KIND_OLDER = 2'd3;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_SELF_BASE = 4'd1;
    localparam logic [3:0] EV_FRGN_BASE = 4'd5;

    localparam logic [15:0] LIFETIME_RESET = 16'd1200;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] router_id;
        logic [31:0] sequence_number;
        logic        from_interface;
        logic [7:0]  interface_index;
    } lsdb_in_t;

    typedef struct packed {
        logic [3:0]  event_code;
        logic        stored;
        logic        flood_request;
        logic        flood_skip_arrival;
        logic        send_back;
        logic [7:0]  target_interface;
        logic        regenerate_request;
        logic [31:0] own_sequence;
        logic [31:0] old_sequence;
        logic [6:0]  expired_count;
        logic [1:0]  error_code;
    } lsdb_out_t;

    // classified word handed from front to back
    typedef struct packed {
        lsdb_in_t word;
        logic     self_rec;
    } lsdb_cmd_t;

endpackage

### hw/rtl/lsdb_front.sv
module lsdb_front
    import lsdb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lsdb_in_t   in_data,
    input  logic [31:0] own_router_id,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output lsdb_cmd_t  cmd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lsdb_cmd_t        fifo_mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_data  = fifo_mem[rd_ptr_reg];

    // classify and enqueue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg].word     <= in_data;
            fifo_mem[wr_ptr_reg].self_rec <= (in_data.router_id == own_router_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

### hw/rtl/lsdb_back.sv
module lsdb_back
    import lsdb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  lsdb_cmd_t   cmd_data,
    input  logic [15:0] lifetime_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output lsdb_out_t   out_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // table: valid bits in flops, keys/sequences/timers in memory
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] router_mem [TABLE_ENTRIES];
    logic [31:0] seq_mem    [TABLE_ENTRIES];
    logic [15:0] life_mem   [TABLE_ENTRIES];

    logic [1:0]  state_reg;
    logic [IW:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic        rd_ok_reg;
    logic [31:0] rd_router_reg, rd_seq_reg;
    logic [15:0] rd_life_reg;
    lsdb_cmd_t   cmd_reg;
    logic        found_reg, free_ok_reg;
    logic [IW-1:0] found_idx_reg, free_idx_reg;
    logic [31:0] found_seq_reg;
    logic [6:0]  count_reg;
    logic        pend_reg;
    logic [31:0] own_seq_reg;
    lsdb_out_t   out_reg;

    logic        wr_en;
    logic [IW-1:0] wr_idx;
    logic [31:0] wr_seq;
    logic [15:0] wr_life;
    logic        wr_key;
    logic [IW-1:0] rd_idx;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;
    assign rd_idx    = idx_reg[IW-1:0];

    // install/remove decision and result word from the finished scan
    logic [1:0]  kind;
    logic        is_self, rx;
    lsdb_out_t   res;
    logic        pend_next;
    logic [31:0] own_seq_next;
    logic        do_store;
    logic [IW-1:0] store_idx;

    always_comb
    begin
        is_self = cmd_reg.self_rec;
        rx      = cmd_reg.word.from_interface;
        if (!found_reg)
            kind = KIND_FRESH;
        else if (cmd_reg.word.sequence_number == found_seq_reg)
            kind = KIND_DUP;
        else if (cmd_reg.word.sequence_number > found_seq_reg)
            kind = KIND_NEWER;
        else
            kind = KIND_OLDER;
        res = '0;
        res.expired_count = count_reg;
        pend_next    = pend_reg;
        own_seq_next = own_seq_reg;
        do_store     = 1'b0;
        store_idx    = (kind == KIND_FRESH) ? free_idx_reg : found_idx_reg;
        case (cmd_reg.word.operation)
            OP_INSTALL:
            begin
                res.old_sequence = found_reg ? found_seq_reg : '0;
                res.event_code = (is_self ? EV_SELF_BASE : EV_FRGN_BASE) + {2'b00, kind};
                if (is_self && !rx)
                    pend_next = 1'b0;
                if (is_self && rx)
                begin
                    if (kind == KIND_FRESH || kind == KIND_NEWER)
                    begin
                        own_seq_next = cmd_reg.word.sequence_number;
                        res.regenerate_request = !pend_reg;
                        pend_next = 1'b1;
                    end
                end
                else if (!rx && (!is_self || kind == KIND_DUP || kind == KIND_OLDER))
                    res.error_code = ERR_LOCAL;
                else if (kind == KIND_FRESH || kind == KIND_NEWER)
                begin
                    if (kind == KIND_FRESH && !free_ok_reg)
                        res.error_code = ERR_FULL;
                    else
                    begin
                        do_store = 1'b1;
                        res.stored = 1'b1;
                        res.flood_request = 1'b1;
                        if (!is_self)
                        begin
                            res.flood_skip_arrival = 1'b1;
                            res.target_interface = cmd_reg.word.interface_index;
                        end
                    end
                end
                else if (kind == KIND_OLDER && !is_self)
                begin
                    res.send_back = 1'b1;
                    res.target_interface = cmd_reg.word.interface_index;
                end
            end
            OP_REMOVE:
            begin
                res.old_sequence  = found_reg ? found_seq_reg : '0;
                res.expired_count = {6'd0, found_reg};
            end
            default: ;
        endcase
        res.own_sequence = own_seq_next;
    end

    // memory write port: install store or tick countdown
    logic        tick_hit;
    always_comb
    begin
        tick_hit = rd_ok_reg && valid_reg[rd_idx_reg] && (rd_life_reg != '0);
        wr_en   = 1'b0;
        wr_key  = 1'b0;
        wr_idx  = rd_idx_reg;
        wr_seq  = cmd_reg.word.sequence_number;
        wr_life = rd_life_reg - 16'd1;
        if (state_reg == ST_DONE && do_store)
        begin
            wr_en   = 1'b1;
            wr_key  = 1'b1;
            wr_idx  = store_idx;
            wr_life = is_self ? 16'd0 :
                      ((lifetime_seconds == '0) ? 16'd1 : lifetime_seconds);
        end
        else if (state_reg == ST_SCAN && cmd_reg.word.operation == OP_TICK && tick_hit)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            life_mem[wr_idx] <= wr_life;
            if (wr_key)
            begin
                router_mem[wr_idx] <= cmd_reg.word.router_id;
                seq_mem[wr_idx]    <= wr_seq;
            end
        end
        rd_router_reg <= router_mem[rd_idx];
        rd_seq_reg    <= seq_mem[rd_idx];
        rd_life_reg   <= life_mem[rd_idx];
        rd_idx_reg    <= rd_idx;
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd_data;
        if (state_reg == ST_DONE)
            out_reg <= res;
    end

    // sequencer: walk the table one slot a cycle, read data registered and checked in the cycle after
    logic hit;
    assign hit = rd_ok_reg && valid_reg[rd_idx_reg]
                 && (rd_router_reg == cmd_reg.word.router_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rd_ok_reg   <= 1'b0;
            valid_reg   <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg  <= '0;
            found_seq_reg <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            own_seq_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg   <= ST_SCAN;
                        idx_reg     <= '0;
                        rd_ok_reg   <= 1'b0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        count_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    rd_ok_reg <= (idx_reg < (IW+1)'(TABLE_ENTRIES));
                    if (idx_reg < (IW+1)'(TABLE_ENTRIES))
                        idx_reg <= idx_reg + 1'b1;
                    if (rd_ok_reg)
                    begin
                        case (cmd_reg.word.operation)
                            OP_INSTALL, OP_REMOVE:
                            begin
                                if (hit && !found_reg)
                                begin
                                    found_reg     <= 1'b1;
                                    found_idx_reg <= rd_idx_reg;
                                    found_seq_reg <= rd_seq_reg;
                                end
                                if (!valid_reg[rd_idx_reg] && !free_ok_reg)
                                begin
                                    free_ok_reg  <= 1'b1;
                                    free_idx_reg <= rd_idx_reg;
                                end
                            end
                            OP_TICK:
                            begin
                                if (tick_hit && rd_life_reg == 16'd1)
                                begin
                                    valid_reg[rd_idx_reg] <= 1'b0;
                                    if (count_reg != 7'd127)
                                        count_reg <= count_reg + 7'd1;
                                end
                            end
                            default:
                            begin
                                if (valid_reg[rd_idx_reg] && count_reg != 7'd127)
                                    count_reg <= count_reg + 7'd1;
                            end
                        endcase
                    end
                    else if (idx_reg == (IW+1)'(TABLE_ENTRIES))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    pend_reg    <= pend_next;
                    own_seq_reg <= own_seq_next;
                    if (do_store)
                        valid_reg[store_idx] <= 1'b1;
                    if (cmd_reg.word.operation == OP_REMOVE && found_reg)
                        valid_reg[found_idx_reg] <= 1'b0;
                    if (cmd_reg.word.operation == OP_CLEAR)
                        valid_reg <= '0;
                    state_reg <= ST_OUT;
                end
                default:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/link_state_db_install.sv
// Link-state record table. Each word takes one walk over the table, one slot
// per cycle through the record memory's read port; a new word is taken only
// after the result of the last one has been taken. A two-word queue in front
// lets the sender move on while the table walk runs. Config writes apply at once.
module link_state_db_install
    import lsdb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  lsdb_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output lsdb_out_t   out_data
);

    logic [31:0] own_id_reg;
    logic [15:0] life_reg;
    logic        cmd_valid, cmd_ready;
    lsdb_cmd_t   cmd_data;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            life_reg   <= LIFETIME_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_OWN_ID)
                own_id_reg <= cfg_data;
            else
                life_reg <= cfg_data[15:0];
        end
    end

    lsdb_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .own_router_id(own_id_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
    );

    lsdb_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .lifetime_seconds(life_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
